@@ sv/bm25_pkg.sv @@
// Shared types, constants and the ranking compare for the BM25 scoring block.
// No dependencies; every other file but bm25_ram imports this package.
`default_nettype none
package bm25_pkg;

    localparam int DOC_SLOTS_DEF = 4096;
    localparam int MAX_TOP_DEF   = 64;

    localparam int DOC_W   = 12;
    localparam int SCORE_W = 32;
    localparam int TF_W    = 16;
    localparam int LEN_W   = 16;
    localparam int IDF_W   = 24;
    localparam int K1_W    = 16;
    localparam int B_W     = 17;
    localparam int INV_W   = 32;
    localparam int CNT_W   = 7;
    localparam int WGT_W   = 24;

    localparam logic [K1_W-1:0]  K1_RST  = 16'd4915;
    localparam logic [B_W-1:0]   B_RST   = 17'd49152;
    localparam logic [B_W-1:0]   B_ONE   = 17'd65536;
    localparam logic [INV_W-1:0] INV_RST = 32'd16777216;
    localparam logic [CNT_W-1:0] CNT_RST = 7'd10;

    localparam logic [1:0] CFG_K1    = 2'd0;
    localparam logic [1:0] CFG_B     = 2'd1;
    localparam logic [1:0] CFG_INV   = 2'd2;
    localparam logic [1:0] CFG_COUNT = 2'd3;

    typedef struct packed {
        logic               valid;
        logic [DOC_W-1:0]   doc;
        logic [SCORE_W-1:0] score;
    } rank_entry_t;

    typedef struct packed {
        rank_entry_t entry;
        logic        above;
    } rank_link_t;

    typedef struct packed {
        logic               clear;
        logic               push;
        logic               pop;
        logic [DOC_W-1:0]   doc;
        logic [SCORE_W-1:0] score;
    } rank_ctrl_t;

    // higher score wins, lower doc wins a tie
    function automatic logic ranks_above(input logic [SCORE_W-1:0] sa,
                                         input logic [DOC_W-1:0] da,
                                         input logic [SCORE_W-1:0] sb,
                                         input logic [DOC_W-1:0] db);
        return (sa > sb) || ((sa == sb) && (da < db));
    endfunction

endpackage
`default_nettype wire

@@ sv/bm25_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bm25_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

@@ sv/bm25_rank_cell.sv @@
// One cell of the sorted top-k chain: holds one ranked entry, takes a new
// entry or its neighbor's on insert, takes the next one on pop. Uses bm25_pkg.
`default_nettype none
module bm25_rank_cell
    import bm25_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire rank_ctrl_t  ctrl,
    input  wire logic        enable,
    input  wire rank_link_t  prev,
    input  wire rank_entry_t next_entry,
    output rank_link_t       link
);
    rank_entry_t entry_reg;
    rank_entry_t entry_next;
    logic        above;

    assign above = !entry_reg.valid ||
                   ranks_above(ctrl.score, ctrl.doc, entry_reg.score, entry_reg.doc);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.clear)
        begin
            entry_next.valid = 1'b0;
        end
        else if (ctrl.push && enable)
        begin
            if (prev.above)
            begin
                entry_next = prev.entry;
            end
            else if (above)
            begin
                entry_next.valid = 1'b1;
                entry_next.doc   = ctrl.doc;
                entry_next.score = ctrl.score;
            end
        end
        else if (ctrl.pop)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg.valid <= 1'b0;
            entry_reg.doc   <= '0;
            entry_reg.score <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

    assign link.entry = entry_reg;
    assign link.above = above;
endmodule
`default_nettype wire

@@ sv/bm25_weight.sv @@
// Multi-cycle BM25 posting contribution: registered multiplies and a
// one-bit-per-cycle restoring divider. Uses bm25_pkg.
`default_nettype none
module bm25_weight
    import bm25_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [TF_W-1:0]    tf,
    input  wire logic [LEN_W-1:0]   len,
    input  wire logic [IDF_W-1:0]   idf,
    input  wire logic [K1_W-1:0]    k1,
    input  wire logic [B_W-1:0]     b,
    input  wire logic [INV_W-1:0]   inv,
    output logic                    done,
    output logic [SCORE_W-1:0]      contrib
);
    typedef enum logic [2:0] {
        W_IDLE, W_RATIO, W_NORM, W_DEN, W_CHECK, W_DIV, W_PROD
    } wstate_t;

    wstate_t          state_reg;
    logic [39:0]      ratio_reg;
    logic [41:0]      norm_reg;
    logic [46:0]      den_reg;
    logic [52:0]      num_reg;
    logic [47:0]      rem_reg;
    logic [24:0]      quo_reg;
    logic [4:0]       cnt_reg;
    logic [WGT_W-1:0] weight_reg;
    logic [SCORE_W-1:0] contrib_reg;
    logic             done_reg;

    logic [47:0] len_prod;
    logic [56:0] b_prod;
    logic [57:0] k1_prod;
    logic [32:0] num_prod;
    logic [47:0] trial;
    logic        fits;
    logic [24:0] quo_next;
    logic [47:0] idf_prod;
    logic [47:0] rem_top;

    assign len_prod = 48'(len) * 48'(inv);
    assign b_prod   = 57'(b) * 57'(ratio_reg);
    assign k1_prod  = 58'(k1) * 58'(norm_reg);
    assign num_prod = 33'(tf) * 33'({1'b0, k1} + 17'd4096);
    assign rem_top  = 48'(num_reg[52:25]);
    assign trial    = {rem_reg[46:0], num_reg[24]};
    assign fits     = trial >= 48'(den_reg);
    assign quo_next = {quo_reg[23:0], fits};
    assign idf_prod = 48'(idf) * 48'(weight_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= W_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                W_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= W_RATIO;
                    end
                end
                W_RATIO:
                begin
                    ratio_reg <= (len == '0) ? 40'd65536 : len_prod[47:8];
                    state_reg <= W_NORM;
                end
                W_NORM:
                begin
                    norm_reg  <= 42'(B_ONE - b) + 42'(b_prod[56:16]);
                    state_reg <= W_DEN;
                end
                W_DEN:
                begin
                    den_reg   <= 47'({tf, 16'd0}) + 47'(k1_prod[57:12]);
                    num_reg   <= {num_prod, 20'd0};
                    state_reg <= W_CHECK;
                end
                W_CHECK:
                begin
                    // zero denominator gives zero weight; a quotient of 2^24 or more saturates
                    if (den_reg == '0)
                    begin
                        weight_reg <= '0;
                        state_reg  <= W_PROD;
                    end
                    else if (rem_top >= 48'(den_reg))
                    begin
                        weight_reg <= '1;
                        state_reg  <= W_PROD;
                    end
                    else
                    begin
                        rem_reg   <= rem_top;
                        quo_reg   <= '0;
                        cnt_reg   <= '0;
                        state_reg <= W_DIV;
                    end
                end
                W_DIV:
                begin
                    rem_reg <= fits ? (trial - 48'(den_reg)) : trial;
                    quo_reg <= quo_next;
                    num_reg <= {num_reg[51:0], 1'b0};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd24)
                    begin
                        weight_reg <= quo_next[24] ? '1 : quo_next[23:0];
                        state_reg  <= W_PROD;
                    end
                end
                W_PROD:
                begin
                    contrib_reg <= idf_prod[47:16];
                    done_reg    <= 1'b1;
                    state_reg   <= W_IDLE;
                end
                default:
                begin
                    state_reg <= W_IDLE;
                end
            endcase
        end
    end

    assign done    = done_reg;
    assign contrib = contrib_reg;
endmodule
`default_nettype wire

@@ sv/bm25_score_accumulate_topk_top.sv @@
// BM25 accumulate and top-k top level. Uses bm25_pkg, bm25_ram, bm25_weight,
// bm25_rank_cell. A posting is weighted by bm25_weight (multiplies, serial
// divider) and added before the next is accepted. A finish walks the touched
// list, one entry a cycle, through list read, mark and score read and chain
// insert, then emits one hit a cycle while m_tready is high. After reset the
// touched-mark RAM is cleared, no item accepted; config writes taken any time.
`default_nettype none
module bm25_score_accumulate_topk_top
    import bm25_pkg::*;
#(
    parameter int DOC_SLOTS = DOC_SLOTS_DEF,
    parameter int MAX_TOP   = MAX_TOP_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [71:0] s_tdata,   // doc_number, term_count, doc_length, term_weight_idf
    input  wire logic [0:0]  s_tuser,   // action
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // hit_doc, hit_score
    output logic             m_tlast,   // hit_last
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    localparam int AW = $clog2(DOC_SLOTS);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_CAPT, S_CALC, S_ADD, S_WALK, S_EMIT
    } state_t;

    state_t state_reg;
    logic [K1_W-1:0]  k1_reg;
    logic [B_W-1:0]   b_reg;
    logic [INV_W-1:0] inv_reg;
    logic [CNT_W-1:0] count_reg;

    logic [DOC_W-1:0] doc_reg;
    logic [TF_W-1:0]  tf_reg;
    logic [LEN_W-1:0] len_reg;
    logic [IDF_W-1:0] idf_reg;
    logic             mark_q_reg;
    logic [SCORE_W-1:0] score_q_reg;
    logic [AW:0]      total_reg;
    logic [AW:0]      idx_reg;
    logic [AW-1:0]    clr_reg;
    logic             p1_reg;
    logic             p2_reg;
    logic [DOC_W-1:0] p2_doc_reg;
    logic             start_reg;

    logic [DOC_W-1:0] in_doc;
    logic             accept;
    logic             issue;
    logic [AW-1:0]    list_rd;
    logic             mark_rd;
    logic [SCORE_W-1:0] score_rd;
    logic [AW-1:0]    look_addr;
    logic             mark_we;
    logic [AW-1:0]    mark_wa;
    logic             mark_wd;
    logic             add_we;
    logic [SCORE_W:0] sum;
    logic [SCORE_W-1:0] sum_sat;
    logic             w_done;
    logic [SCORE_W-1:0] w_contrib;
    logic [B_W-1:0]   b_use;
    logic [CNT_W-1:0] limit;
    rank_ctrl_t       ctrl;
    rank_link_t       links [MAX_TOP];

    assign in_doc   = s_tdata[11:0];
    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign b_use    = (b_reg > B_ONE) ? B_ONE : b_reg;
    assign limit    = (count_reg > CNT_W'(MAX_TOP)) ? CNT_W'(MAX_TOP) : count_reg;
    assign issue    = (state_reg == S_WALK) && (idx_reg < total_reg);
    assign look_addr = (state_reg == S_WALK) ? list_rd : AW'(in_doc);
    assign add_we   = (state_reg == S_ADD);

    always_comb
    begin
        mark_we = 1'b0;
        mark_wa = AW'(doc_reg);
        mark_wd = 1'b0;
        if (state_reg == S_CLEAR)
        begin
            mark_we = 1'b1;
            mark_wa = clr_reg;
        end
        else if (add_we)
        begin
            mark_we = 1'b1;
            mark_wd = 1'b1;
        end
        else if (p1_reg)
        begin
            mark_we = 1'b1;
            mark_wa = list_rd;
        end
    end

    assign sum     = {1'b0, (mark_q_reg ? score_q_reg : '0)} + {1'b0, w_contrib};
    assign sum_sat = sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];

    bm25_ram #(.WIDTH(1), .DEPTH(DOC_SLOTS)) u_mark (
        .clk(clk), .wr_en(mark_we), .wr_addr(mark_wa), .wr_data(mark_wd),
        .rd_addr(look_addr), .rd_data(mark_rd)
    );

    bm25_ram #(.WIDTH(SCORE_W), .DEPTH(DOC_SLOTS)) u_score (
        .clk(clk), .wr_en(add_we), .wr_addr(AW'(doc_reg)), .wr_data(sum_sat),
        .rd_addr(look_addr), .rd_data(score_rd)
    );

    bm25_ram #(.WIDTH(AW), .DEPTH(DOC_SLOTS)) u_list (
        .clk(clk), .wr_en(add_we && !mark_q_reg), .wr_addr(total_reg[AW-1:0]),
        .wr_data(AW'(doc_reg)), .rd_addr(idx_reg[AW-1:0]), .rd_data(list_rd)
    );

    bm25_weight u_weight (
        .clk(clk), .rst_n(rst_n), .start(start_reg),
        .tf(tf_reg), .len(len_reg), .idf(idf_reg),
        .k1(k1_reg), .b(b_use), .inv(inv_reg),
        .done(w_done), .contrib(w_contrib)
    );

    assign ctrl.clear = accept && s_tuser[0];
    assign ctrl.push  = p2_reg;
    assign ctrl.pop   = m_tvalid && m_tready;
    assign ctrl.doc   = p2_doc_reg;
    assign ctrl.score = score_rd;

    for (genvar i = 0; i < MAX_TOP; i++)
    begin : g_cell
        rank_link_t  prev_link;
        rank_entry_t next_ent;
        if (i == 0)
        begin : g_head
            assign prev_link = '0;
        end
        else
        begin : g_mid
            assign prev_link = links[i-1];
        end
        if (i == MAX_TOP - 1)
        begin : g_tail
            assign next_ent = '0;
        end
        else
        begin : g_body
            assign next_ent = links[i+1].entry;
        end
        bm25_rank_cell u_cell (
            .clk(clk), .rst_n(rst_n), .ctrl(ctrl),
            .enable(CNT_W'(i) < limit), .prev(prev_link),
            .next_entry(next_ent), .link(links[i])
        );
    end

    assign m_tvalid = (state_reg == S_EMIT) && links[0].entry.valid;
    assign m_tdata  = {4'd0, links[0].entry.score, links[0].entry.doc};
    if (MAX_TOP == 1)
    begin : g_last_one
        assign m_tlast = 1'b1;
    end
    else
    begin : g_last_many
        assign m_tlast = !links[1].entry.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_reg    <= K1_RST;
            b_reg     <= B_RST;
            inv_reg   <= INV_RST;
            count_reg <= CNT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_K1:    k1_reg    <= cfg_data[K1_W-1:0];
                CFG_B:     b_reg     <= cfg_data[B_W-1:0];
                CFG_INV:   inv_reg   <= cfg_data;
                CFG_COUNT: count_reg <= cfg_data[CNT_W-1:0];
                default:   k1_reg    <= k1_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            doc_reg <= in_doc;
            tf_reg  <= s_tdata[27:12];
            len_reg <= s_tdata[43:28];
            idf_reg <= s_tdata[67:44];
        end
        if (state_reg == S_CAPT)
        begin
            mark_q_reg  <= mark_rd;
            score_q_reg <= score_rd;
        end
        if (p1_reg)
        begin
            p2_doc_reg <= DOC_W'(list_rd);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            total_reg <= '0;
            idx_reg   <= '0;
            p1_reg    <= 1'b0;
            p2_reg    <= 1'b0;
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            p1_reg    <= issue;
            p2_reg    <= p1_reg;
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(DOC_SLOTS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (s_tuser[0])
                        begin
                            idx_reg   <= '0;
                            state_reg <= S_WALK;
                        end
                        else if (32'(in_doc) < 32'(DOC_SLOTS))
                        begin
                            state_reg <= S_CAPT;
                        end
                    end
                end
                S_CAPT:
                begin
                    start_reg <= 1'b1;
                    state_reg <= S_CALC;
                end
                S_CALC:
                begin
                    if (w_done)
                    begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD:
                begin
                    if (!mark_q_reg)
                    begin
                        total_reg <= total_reg + 1'b1;
                    end
                    state_reg <= S_IDLE;
                end
                S_WALK:
                begin
                    if (issue)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else if (!p1_reg && !p2_reg)
                    begin
                        total_reg <= '0;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    // leave once the last hit has gone out, or when there is no hit
                    if (!links[0].entry.valid || (m_tready && m_tlast))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_out_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (state_reg == S_EMIT))
        else $error("hit shown outside emit");
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= (AW+1)'(DOC_SLOTS))
        else $error("touched count overflow");
    a_push_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        p2_reg |-> (state_reg == S_WALK))
        else $error("chain insert outside walk");
    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        w_done |-> (state_reg == S_CALC))
        else $error("weight done unexpected");
`endif
endmodule
`default_nettype wire

@@ test/bm25_score_accumulate_topk_top_tb.sv @@
// Testbench for the BM25 accumulate and top-k block: drives postings and finish
// items, predicts the ranked hits and compares each one. Depends on bm25_pkg and the RTL.
module bm25_score_accumulate_topk_top_tb
    import bm25_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic ACT_POST   = 1'b0;
    localparam logic ACT_FINISH = 1'b1;
    localparam int CYCLE_LIMIT  = 1500000;

    typedef struct {
        logic [DOC_W-1:0]   doc;
        logic [SCORE_W-1:0] score;
        logic               last;
    } hit_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [71:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    bm25_score_accumulate_topk_top u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // predictor state
    logic [K1_W-1:0]    k1_q = K1_RST;
    logic [B_W-1:0]     b_q = B_RST;
    logic [INV_W-1:0]   inv_q = INV_RST;
    logic [CNT_W-1:0]   count_q = CNT_RST;
    logic [SCORE_W-1:0] doc_score [DOC_SLOTS_DEF];
    bit                 doc_marked [DOC_SLOTS_DEF];
    logic [DOC_W-1:0]   marked_docs [$];
    hit_t               expected_hits [$];

    int  mismatches = 0;
    longint cycles = 0;
    bit  hold_off = 1'b0;
    bit  stall_enable = 1'b1;

    function automatic logic [SCORE_W-1:0] bm25_term(logic [15:0] tf, logic [15:0] len,
                                                     logic [23:0] idf);
        logic [63:0] b, ratio, norm, den, weight, contrib;
        b = (b_q > B_ONE) ? 64'd65536 : 64'(b_q);
        ratio = (len != 0) ? ((64'(len) * 64'(inv_q)) >> 8) : 64'd65536;
        norm = (64'd65536 - b) + ((b * ratio) >> 16);
        den = (64'(tf) << 16) + ((64'(k1_q) * norm) >> 12);
        weight = 0;
        if (den != 0)
        begin
            weight = ((64'(tf) * (64'(k1_q) + 64'd4096)) << 20) / den;
            if (weight > 64'hFFFFFF) weight = 64'hFFFFFF;
        end
        contrib = (64'(idf) * weight) >> 16;
        if (contrib > 64'hFFFFFFFF) contrib = 64'hFFFFFFFF;
        return contrib[31:0];
    endfunction

    function automatic bit outranks(logic [31:0] sa, logic [11:0] da,
                                    logic [31:0] sb, logic [11:0] db);
        return (sa > sb) || (sa == sb && da < db);
    endfunction

    function automatic void predict_posting(logic [11:0] doc, logic [15:0] tf,
                                            logic [15:0] len, logic [23:0] idf);
        logic [32:0] sum;
        if (!doc_marked[doc])
        begin
            doc_marked[doc] = 1'b1;
            doc_score[doc] = '0;
            marked_docs.insert(marked_docs.size(), doc);
        end
        sum = 33'(doc_score[doc]) + 33'(bm25_term(tf, len, idf));
        doc_score[doc] = sum[32] ? 32'hFFFFFFFF : sum[31:0];
    endfunction

    function automatic void predict_ranking();
        hit_t ranked [$];
        hit_t h;
        int limit, pos;
        limit = (count_q > MAX_TOP_DEF) ? MAX_TOP_DEF : int'(count_q);
        foreach (marked_docs[i])
        begin
            h.doc = marked_docs[i];
            h.score = doc_score[h.doc];
            h.last = 1'b0;
            pos = ranked.size();
            while (pos > 0 && outranks(h.score, h.doc, ranked[pos-1].score, ranked[pos-1].doc))
                pos--;
            ranked.insert(pos, h);
            if (ranked.size() > limit) ranked.pop_back();
        end
        foreach (ranked[i])
        begin
            ranked[i].last = (i == ranked.size() - 1);
            expected_hits.insert(expected_hits.size(), ranked[i]);
        end
        foreach (marked_docs[i]) doc_marked[marked_docs[i]] = 1'b0;
        marked_docs.delete();
    endfunction

    // valid stays up after a transaction; drop it only when idling before the next one
    task automatic send_item(logic act, logic [11:0] doc, logic [15:0] tf,
                             logic [15:0] len, logic [23:0] idf);
        int gap;
        gap = stall_enable ? $urandom_range(0, 19) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= {idf, len, tf, doc};
        do @(posedge clk); while (!s_tready);
        if (act == ACT_POST) predict_posting(doc, tf, len, idf);
        else predict_ranking();
    endtask

    task automatic post(logic [11:0] doc, logic [15:0] tf, logic [15:0] len, logic [23:0] idf);
        send_item(ACT_POST, doc, tf, len, idf);
    endtask

    task automatic finish_query();
        send_item(ACT_FINISH, 12'($urandom), 16'($urandom), 16'($urandom), 24'($urandom));
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_K1:    k1_q = value[15:0];
            CFG_B:     b_q = value[16:0];
            CFG_INV:   inv_q = value;
            CFG_COUNT: count_q = value[6:0];
            default: ;
        endcase
    endtask

    // postings never produce hits, so a drained queue plus a margin means idle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic random_posting(int doc_span);
        post(12'($urandom_range(0, doc_span)), ($urandom_range(0, 3) == 0) ? 16'($urandom)
             : 16'($urandom_range(0, 20)), 16'($urandom), 24'($urandom));
    endtask

    task automatic test_directed();
        post(12'd0, 16'd0, 16'd0, 24'd0);
        post(12'd4095, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
        post(12'd4095, 16'hFFFF, 16'hFFFF, 24'hFFFFFF);
        post(12'd7, 16'd3, 16'd0, 24'h010000);
        post(12'd5, 16'd3, 16'd0, 24'h010000);
        post(12'd2730, 16'd1, 16'h5555, 24'hAAAAAA);
        post(12'd1365, 16'd2, 16'hAAAA, 24'h555555);
        finish_query();
        finish_query();
        wait_idle();
        // zero denominator: k1 zero and tf zero
        write_reg(CFG_K1, 32'd0);
        write_reg(CFG_B, 32'h1FFFF);
        write_reg(CFG_INV, 32'hFFFFFFFF);
        write_reg(CFG_COUNT, 32'd0);
        post(12'd9, 16'd0, 16'd100, 24'd500);
        post(12'd10, 16'd4, 16'd100, 24'd500);
        finish_query();
        wait_idle();
        write_reg(CFG_COUNT, 32'd127);
        post(12'd9, 16'd0, 16'd100, 24'd500);
        post(12'd11, 16'd1, 16'd1, 24'hFFFFFF);
        finish_query();
        wait_idle();
    endtask

    task automatic test_settings(int queries);
        logic [31:0] counts [4] = '{32'd1, 32'd64, 32'd10, 32'd70};
        for (int q = 0; q < queries; q++)
        begin
            if (q % 4 == 0)
            begin
                write_reg(CFG_K1, (q % 8 == 0) ? 32'hFFFF : 32'($urandom));
                write_reg(CFG_B, (q % 8 == 0) ? 32'd0 : 32'($urandom_range(0, 70000)));
                write_reg(CFG_INV, 32'($urandom));
                write_reg(CFG_COUNT, counts[(q / 4) % 4]);
            end
            for (int n = $urandom_range(3, 24); n > 0; n--) random_posting(80);
            finish_query();
            if (q % 4 == 3) wait_idle();
        end
        wait_idle();
    endtask

    task automatic test_backpressure();
        write_reg(CFG_COUNT, 32'd64);
        stall_enable = 1'b0;
        for (int n = 0; n < 70; n++) random_posting(4095);
        hold_off = 1'b1;
        finish_query();
        for (int n = 0; n < 5; n++) random_posting(4095);
        finish_query();
        hold_off = 1'b0;
        stall_enable = 1'b1;
        wait_idle();
    endtask

    // receiver: random stalls plus a long hold-off when asked
    initial
    begin
        int gap;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                m_tready <= 1'b0;
                repeat (800) @(posedge clk);
                hold_off = 1'b0;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
            m_tready <= (gap == 0) ? 1'b1 : 1'b0;
            if (gap != 0)
            begin
                repeat (gap) @(posedge clk);
                m_tready <= 1'b1;
            end
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    always @(posedge clk)
    begin
        hit_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_hits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected hit doc %0d score %h", m_tdata[11:0], m_tdata[43:12]);
            end
            else
            begin
                want = expected_hits.pop_front();
                if (m_tdata[11:0] !== want.doc || m_tdata[43:12] !== want.score
                    || m_tlast !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("hit mismatch: expected doc %0d score %h last %b, got %0d %h %b",
                                 want.doc, want.score, want.last,
                                 m_tdata[11:0], m_tdata[43:12], m_tlast);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("bm25_score_accumulate_topk_top verification failed");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_settings(16);
        test_backpressure();
        wait_idle();
        if (mismatches == 0 && expected_hits.size() == 0)
            $display("bm25_score_accumulate_topk_top verification clean");
        else
            $display("bm25_score_accumulate_topk_top verification failed");
        $finish;
    end
endmodule

@@ filelist.f @@
sv/bm25_pkg.sv
sv/bm25_ram.sv
sv/bm25_rank_cell.sv
sv/bm25_weight.sv
sv/bm25_score_accumulate_topk_top.sv
test/bm25_score_accumulate_topk_top_tb.sv
